/* hw/rtl/dofq_pkg.sv */
// Package for the drop-oldest frame queue: action, result kind and register codes,
// fixed field widths and the sequencer state type.
// No dependencies; used by drop_oldest_frame_queue_core.
package dofq_pkg;

  // Fixed field widths
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned FLAGS_W    = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned OUT_TAG_W  = 16;
  localparam int unsigned OUT_LEN_W  = 16;
  localparam int unsigned MAXF_W     = 7;
  localparam int unsigned BYTE_W     = 22;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned DBYTES_W   = 48;
  localparam int unsigned QCOUNT_W   = 7;

  localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PULL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PUSHED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL,
    ST_CHECK,
    ST_DROP,
    ST_PULL
  } state_t;

endpackage

/* hw/rtl/drop_oldest_frame_queue_core.sv */
// Drop-oldest frame descriptor queue, bounded by frame count and queued bytes.
// Holds the descriptor memory and the drop sequencer.
// Depends on dofq_pkg.

// Usage: one item is taken at a rising edge with start high and busy low; each item
// yields exactly one result, shown for one cycle with out_strobe high, and the
// receiver cannot stall it. Close, pull of a pending dropped event, an empty pull,
// a direct-mode push and any item after close answer in the cycle after acceptance
// and never raise busy. A frame-delivering pull goes through ST_PULL (one registered
// read of the descriptor memory). A queued push goes through ST_CHECK, via ST_FULL
// when the store already holds DEPTH frames, then via ST_DROP and ST_CHECK again for
// each head frame dropped over a limit: the drop loop reads one head descriptor and
// removes it per iteration through the single memory read port. The next item may
// be started in the cycle the previous result is strobed. Counter and queue level
// outputs are valid while out_strobe is high. Only a reset reopens a closed queue.
module drop_oldest_frame_queue_core #(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned LEN_BITS = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [dofq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dofq_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [dofq_pkg::ACTION_W-1:0]         in_action,
  input  logic [TAG_BITS-1:0]                   in_frame_tag,
  input  logic [LEN_BITS-1:0]                   in_frame_length,
  input  logic [dofq_pkg::FLAGS_W-1:0]          in_frame_flags,
  // Result channel
  output logic                                  out_strobe,
  output logic [dofq_pkg::KIND_W-1:0]           out_kind,
  output logic [dofq_pkg::OUT_TAG_W-1:0]        out_tag,
  output logic [dofq_pkg::OUT_LEN_W-1:0]        out_length,
  output logic [dofq_pkg::FLAGS_W-1:0]          out_flags,
  output logic                                  out_discontinuity,
  output logic [dofq_pkg::CNT_W-1:0]            out_dropped_frame_total,
  output logic [dofq_pkg::DBYTES_W-1:0]         out_dropped_byte_total,
  output logic [dofq_pkg::CNT_W-1:0]            out_received_total,
  output logic [dofq_pkg::CNT_W-1:0]            out_delivered_total,
  output logic [dofq_pkg::QCOUNT_W-1:0]         out_queued_count,
  output logic [dofq_pkg::BYTE_W-1:0]           out_queued_byte_count
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned BC_W  = LEN_BITS + CW;
  localparam int unsigned ENT_W = TAG_BITS + LEN_BITS + dofq_pkg::FLAGS_W;
  // Compare widths: queue level vs. register limits
  localparam int unsigned CCW   = (CW > dofq_pkg::MAXF_W) ? CW : dofq_pkg::MAXF_W;
  localparam int unsigned BCMPW = (BC_W > dofq_pkg::BYTE_W) ? BC_W : dofq_pkg::BYTE_W;

  // Configuration registers
  logic [dofq_pkg::MAXF_W-1:0] max_frames_r;
  logic [dofq_pkg::BYTE_W-1:0] max_bytes_r;
  logic                        direct_r;

  // Sequencer and queue state
  dofq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [BC_W-1:0]  bytes_r, bytes_nxt;
  logic             pending_r, pending_nxt;
  logic             closed_r, closed_nxt;
  logic             head_disc_r, head_disc_nxt;
  logic             dropped_r, dropped_nxt;
  logic [dofq_pkg::CNT_W-1:0]    rx_cnt_r, rx_cnt_nxt;
  logic [dofq_pkg::CNT_W-1:0]    dlv_cnt_r, dlv_cnt_nxt;
  logic [dofq_pkg::CNT_W-1:0]    drop_cnt_r, drop_cnt_nxt;
  logic [dofq_pkg::DBYTES_W-1:0] drop_bytes_r, drop_bytes_nxt;
  logic             strobe_r, strobe_nxt;

  // Latched item and result payload
  logic [TAG_BITS-1:0]          item_tag_r, item_tag_nxt;
  logic [LEN_BITS-1:0]          item_len_r, item_len_nxt;
  logic [dofq_pkg::FLAGS_W-1:0] item_flags_r, item_flags_nxt;
  logic [dofq_pkg::KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [dofq_pkg::OUT_TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic [dofq_pkg::OUT_LEN_W-1:0] out_len_r, out_len_nxt;
  logic [dofq_pkg::FLAGS_W-1:0]   out_flags_r, out_flags_nxt;
  logic                           out_disc_r, out_disc_nxt;

  // Descriptor memory: {tag, length, flags}
  logic [ENT_W-1:0] frame_mem_r [DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;

  logic [TAG_BITS-1:0]          rd_tag;
  logic [LEN_BITS-1:0]          rd_len;
  logic [dofq_pkg::FLAGS_W-1:0] rd_flags;
  logic [AW-1:0]                head_inc;
  logic [AW:0]                  tail_sum;
  logic [AW-1:0]                tail;
  logic                         over_limit;

  assign rd_tag   = rd_data_r[ENT_W-1 -: TAG_BITS];
  assign rd_len   = rd_data_r[LEN_BITS + dofq_pkg::FLAGS_W - 1 : dofq_pkg::FLAGS_W];
  assign rd_flags = rd_data_r[dofq_pkg::FLAGS_W-1:0];

  // Ring pointer arithmetic; DEPTH need not be a power of two
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_sum = (AW+1)'(head_r) + (AW+1)'(count_r);
  assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : AW'(tail_sum);

  // A zero limit disables that check
  assign over_limit =
      ((max_frames_r != '0) && (CCW'(count_r) > CCW'(max_frames_r))) ||
      ((max_bytes_r != '0) && (BCMPW'(bytes_r) > BCMPW'(max_bytes_r)));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frames_r <= '0;
      max_bytes_r  <= '0;
      direct_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dofq_pkg::CFG_MAX_FRAMES: max_frames_r <= cfg_data[dofq_pkg::MAXF_W-1:0];
        dofq_pkg::CFG_MAX_BYTES:  max_bytes_r  <= cfg_data[dofq_pkg::BYTE_W-1:0];
        dofq_pkg::CFG_DIRECT:     direct_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Descriptor memory: one write port, registered read of the current head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= frame_mem_r[head_r];
  end

  // Sequencer: next state, queue updates and result
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    bytes_nxt      = bytes_r;
    pending_nxt    = pending_r;
    closed_nxt     = closed_r;
    head_disc_nxt  = head_disc_r;
    dropped_nxt    = dropped_r;
    rx_cnt_nxt     = rx_cnt_r;
    dlv_cnt_nxt    = dlv_cnt_r;
    drop_cnt_nxt   = drop_cnt_r;
    drop_bytes_nxt = drop_bytes_r;
    strobe_nxt     = 1'b0;
    item_tag_nxt   = item_tag_r;
    item_len_nxt   = item_len_r;
    item_flags_nxt = item_flags_r;
    out_kind_nxt   = out_kind_r;
    out_tag_nxt    = out_tag_r;
    out_len_nxt    = out_len_r;
    out_flags_nxt  = out_flags_r;
    out_disc_nxt   = out_disc_r;
    wr_en          = 1'b0;
    wr_addr        = tail;
    wr_data        = {in_frame_tag, in_frame_length, in_frame_flags};

    unique case (state_r)
      dofq_pkg::ST_IDLE: begin
        if (start) begin
          item_tag_nxt   = in_frame_tag;
          item_len_nxt   = in_frame_length;
          item_flags_nxt = in_frame_flags;
          dropped_nxt    = 1'b0;
          // Most answers are immediate; clear the frame fields for them
          out_kind_nxt   = dofq_pkg::KIND_NONE;
          out_tag_nxt    = '0;
          out_len_nxt    = '0;
          out_flags_nxt  = '0;
          out_disc_nxt   = 1'b0;
          if (closed_r) begin
            strobe_nxt = 1'b1;
          end else begin
            unique case (in_action)
              dofq_pkg::ACT_PUSH: begin
                rx_cnt_nxt = rx_cnt_r + dofq_pkg::CNT_W'(1);
                if (direct_r) begin
                  // Bypass the queue
                  dlv_cnt_nxt   = dlv_cnt_r + dofq_pkg::CNT_W'(1);
                  out_kind_nxt  = dofq_pkg::KIND_FRAME;
                  out_tag_nxt   = dofq_pkg::OUT_TAG_W'(in_frame_tag);
                  out_len_nxt   = dofq_pkg::OUT_LEN_W'(in_frame_length);
                  out_flags_nxt = in_frame_flags;
                  strobe_nxt    = 1'b1;
                end else if (count_r >= CW'(DEPTH)) begin
                  // Store full: drop the head first
                  state_nxt = dofq_pkg::ST_FULL;
                end else begin
                  wr_en     = 1'b1;
                  count_nxt = count_r + CW'(1);
                  bytes_nxt = bytes_r + BC_W'(in_frame_length);
                  state_nxt = dofq_pkg::ST_CHECK;
                end
              end
              dofq_pkg::ACT_PULL: begin
                if (pending_r) begin
                  pending_nxt  = 1'b0;
                  out_kind_nxt = dofq_pkg::KIND_DROPPED;
                  strobe_nxt   = 1'b1;
                end else if (count_r != '0) begin
                  state_nxt = dofq_pkg::ST_PULL;
                end else begin
                  strobe_nxt = 1'b1;
                end
              end
              dofq_pkg::ACT_CLOSE: begin
                closed_nxt    = 1'b1;
                head_nxt      = '0;
                count_nxt     = '0;
                bytes_nxt     = '0;
                pending_nxt   = 1'b0;
                head_disc_nxt = 1'b0;
                out_kind_nxt  = dofq_pkg::KIND_CLOSED;
                strobe_nxt    = 1'b1;
              end
              default: begin
                strobe_nxt = 1'b1;
              end
            endcase
          end
        end
      end

      dofq_pkg::ST_FULL: begin
        // Drop the head and write the new frame into its slot; level stays DEPTH
        wr_en          = 1'b1;
        wr_addr        = head_r;
        wr_data        = {item_tag_r, item_len_r, item_flags_r};
        head_nxt       = head_inc;
        bytes_nxt      = bytes_r - BC_W'(rd_len) + BC_W'(item_len_r);
        drop_cnt_nxt   = drop_cnt_r + dofq_pkg::CNT_W'(1);
        drop_bytes_nxt = drop_bytes_r + dofq_pkg::DBYTES_W'(rd_len);
        head_disc_nxt  = 1'b0;
        dropped_nxt    = 1'b1;
        state_nxt      = dofq_pkg::ST_CHECK;
      end

      dofq_pkg::ST_CHECK: begin
        // The registered read of the current head descriptor is taken here for ST_DROP
        if ((count_r != '0) && over_limit) begin
          state_nxt = dofq_pkg::ST_DROP;
        end else begin
          if (dropped_r) begin
            pending_nxt   = 1'b1;
            head_disc_nxt = (count_r != '0);
          end
          out_kind_nxt = dofq_pkg::KIND_PUSHED;
          strobe_nxt   = 1'b1;
          state_nxt    = dofq_pkg::ST_IDLE;
        end
      end

      dofq_pkg::ST_DROP: begin
        head_nxt       = head_inc;
        count_nxt      = count_r - CW'(1);
        bytes_nxt      = bytes_r - BC_W'(rd_len);
        drop_cnt_nxt   = drop_cnt_r + dofq_pkg::CNT_W'(1);
        drop_bytes_nxt = drop_bytes_r + dofq_pkg::DBYTES_W'(rd_len);
        head_disc_nxt  = 1'b0;
        dropped_nxt    = 1'b1;
        state_nxt      = dofq_pkg::ST_CHECK;
      end

      dofq_pkg::ST_PULL: begin
        out_kind_nxt  = dofq_pkg::KIND_FRAME;
        out_tag_nxt   = dofq_pkg::OUT_TAG_W'(rd_tag);
        out_len_nxt   = dofq_pkg::OUT_LEN_W'(rd_len);
        out_flags_nxt = rd_flags;
        out_disc_nxt  = head_disc_r;
        head_nxt      = head_inc;
        count_nxt     = count_r - CW'(1);
        bytes_nxt     = bytes_r - BC_W'(rd_len);
        dlv_cnt_nxt   = dlv_cnt_r + dofq_pkg::CNT_W'(1);
        head_disc_nxt = 1'b0;
        strobe_nxt    = 1'b1;
        state_nxt     = dofq_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = dofq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dofq_pkg::ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      bytes_r      <= '0;
      pending_r    <= 1'b0;
      closed_r     <= 1'b0;
      head_disc_r  <= 1'b0;
      dropped_r    <= 1'b0;
      rx_cnt_r     <= '0;
      dlv_cnt_r    <= '0;
      drop_cnt_r   <= '0;
      drop_bytes_r <= '0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      bytes_r      <= bytes_nxt;
      pending_r    <= pending_nxt;
      closed_r     <= closed_nxt;
      head_disc_r  <= head_disc_nxt;
      dropped_r    <= dropped_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
      dlv_cnt_r    <= dlv_cnt_nxt;
      drop_cnt_r   <= drop_cnt_nxt;
      drop_bytes_r <= drop_bytes_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    item_tag_r   <= item_tag_nxt;
    item_len_r   <= item_len_nxt;
    item_flags_r <= item_flags_nxt;
    out_kind_r   <= out_kind_nxt;
    out_tag_r    <= out_tag_nxt;
    out_len_r    <= out_len_nxt;
    out_flags_r  <= out_flags_nxt;
    out_disc_r   <= out_disc_nxt;
  end

  // Outputs
  assign busy                    = (state_r != dofq_pkg::ST_IDLE);
  assign out_strobe              = strobe_r;
  assign out_kind                = out_kind_r;
  assign out_tag                 = out_tag_r;
  assign out_length              = out_len_r;
  assign out_flags               = out_flags_r;
  assign out_discontinuity       = out_disc_r;
  assign out_dropped_frame_total = drop_cnt_r;
  assign out_dropped_byte_total  = drop_bytes_r;
  assign out_received_total      = rx_cnt_r;
  assign out_delivered_total     = dlv_cnt_r;
  assign out_queued_count        = dofq_pkg::QCOUNT_W'(count_r);
  // Saturate the byte level at the field maximum
  assign out_queued_byte_count   =
      (BCMPW'(bytes_r) > BCMPW'(dofq_pkg::BYTE_MAX)) ? dofq_pkg::BYTE_MAX
                                                     : dofq_pkg::BYTE_W'(bytes_r);

  // Assertions
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue level above DEPTH");

  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> (count_r == '0) && !pending_r)
    else $error("closed queue still holds frames or an event");

  a_empty_no_disc: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !head_disc_r)
    else $error("discontinuity mark on an empty queue");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(start && (state_r == dofq_pkg::ST_IDLE)) ||
                 $past(state_r == dofq_pkg::ST_CHECK) ||
                 $past(state_r == dofq_pkg::ST_PULL))
    else $error("result strobe without a finishing item");

endmodule
